@@ sv/pibe_pkg.sv @@
`timescale 1ns / 1ps

package pibe_pkg;

    // Default geometry of the store
    localparam int PACKET_COUNT_DEF = 64;
    localparam int PACKET_BYTES_DEF = 64;
    localparam int MAX_STRIPE_DEF   = 16;

    // Field widths fixed by the word format
    localparam int DONE_W     = 7;
    localparam int ERASED_W   = 13;
    localparam int FIRST_W    = 6;
    localparam int BURST_W    = 7;
    localparam int STRIPE_W   = 5;
    localparam int IN_USE_W   = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STRIPE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_USE = 1'b1;

    // Reset values of the configuration registers
    localparam logic [STRIPE_W-1:0] STRIPE_RESET = 5'd1;
    localparam logic [IN_USE_W-1:0] IN_USE_RESET = 7'd64;

    // Byte written by an erase burst
    localparam logic [7:0] ERASE_FILL = 8'hFF;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_ERASE  = 2'd2,
        OP_REWIND = 2'd3
    } pibe_op_t;

    typedef enum logic {
        ST_RUN,
        ST_ERASE
    } pibe_state_t;

    typedef struct packed {
        pibe_op_t           opcode;
        logic [7:0]         data_byte;
        logic               end_of_buffer;
        logic [FIRST_W-1:0] burst_first_packet;
        logic [BURST_W-1:0] burst_packets;
    } pibe_in_t;

    typedef struct packed {
        logic [7:0]          read_data;
        logic [DONE_W-1:0]   packets_done;
        logic                pass_complete;
        logic [ERASED_W-1:0] erased_bytes;
        logic                overflow;
    } pibe_out_t;

endpackage

@@ sv/pibe_ram.sv @@
`timescale 1ns / 1ps

module pibe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/pibe_cursor.sv @@
`timescale 1ns / 1ps

module pibe_cursor #(
    parameter int PACKET_COUNT = pibe_pkg::PACKET_COUNT_DEF,
    parameter int PACKET_BYTES = pibe_pkg::PACKET_BYTES_DEF,
    parameter int MAX_STRIPE   = pibe_pkg::MAX_STRIPE_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic [$clog2(MAX_STRIPE + 1)-1:0]            stripe,
    input  logic                                         step,
    input  logic                                         clear,
    output logic [$clog2(PACKET_COUNT * PACKET_BYTES)-1:0] addr,
    output logic                                         in_range,
    output logic                                         group_end,
    output logic [$clog2(PACKET_COUNT + 1)-1:0]          base_next,
    output logic [pibe_pkg::DONE_W-1:0]                  base_plus_stripe
);

    import pibe_pkg::*;

    localparam int AW  = $clog2(PACKET_COUNT * PACKET_BYTES);
    localparam int BW  = $clog2(PACKET_COUNT + 1);
    localparam int SW  = $clog2(MAX_STRIPE + 1);
    localparam int OW  = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
    localparam int LW  = (MAX_STRIPE > 1) ? $clog2(MAX_STRIPE) : 1;
    localparam int SMW = ((BW > SW) ? BW : SW) + 1;
    localparam int PKW = ((BW > LW) ? BW : LW) + 1;

    logic [BW-1:0]  base_reg, base_nx;
    logic [OW-1:0]  offset_reg, offset_next;
    logic [LW-1:0]  lane_reg, lane_next;
    logic [SW-1:0]  lane_inc;
    logic           lane_wrap;
    logic           offset_last;
    logic [SMW-1:0] base_sum;
    logic [PKW-1:0] pkt;
    logic [AW-1:0]  pkt_a;

    // Locate the byte under the cursor
    always_comb
    begin
        pkt      = PKW'(base_reg) + PKW'(lane_reg);
        in_range = (pkt < PKW'(PACKET_COUNT));
        pkt_a    = AW'(pkt);
        addr     = pkt_a * AW'(PACKET_BYTES) + AW'(offset_reg);
    end

    // Work out the advanced position
    always_comb
    begin
        lane_inc         = SW'(lane_reg) + SW'(1);
        lane_wrap        = (lane_inc >= stripe);
        offset_last      = (offset_reg == OW'(PACKET_BYTES - 1));
        group_end        = lane_wrap && offset_last;
        base_sum         = SMW'(base_reg) + SMW'(stripe);
        base_plus_stripe = DONE_W'(base_sum);
        base_next        = (base_sum > SMW'(PACKET_COUNT)) ? BW'(PACKET_COUNT) : BW'(base_sum);
    end

    // Select the next cursor
    always_comb
    begin
        base_nx     = base_reg;
        offset_next = offset_reg;
        lane_next   = lane_reg;
        if (clear)
        begin
            base_nx     = '0;
            offset_next = '0;
            lane_next   = '0;
        end
        else if (step)
        begin
            lane_next = lane_wrap ? '0 : LW'(lane_inc);
            if (lane_wrap)
            begin
                offset_next = offset_last ? '0 : offset_reg + OW'(1);
                if (offset_last)
                begin
                    base_nx = base_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            offset_reg <= '0;
            lane_reg   <= '0;
        end
        else
        begin
            base_reg   <= base_nx;
            offset_reg <= offset_next;
            lane_reg   <= lane_next;
        end
    end

endmodule

@@ sv/packet_interleaver_with_burst_erasure_top.sv @@
`timescale 1ns / 1ps

// Channel | Direction | Handshake             | Word
// in      | input     | in_valid / in_ready   | pibe_in_t: opcode, byte, burst fields
// out     | output    | out_valid / out_ready | pibe_out_t: read byte, pass and erase status
// cfg     | input     | cfg_we                | cfg_index selects stripe or packets in use
//
// Write, read and rewind words are taken one per cycle while no erase walk runs and
// the output is not stalled; a result passes through the pending stage (store read and
// status at the accepting edge) and then the output register.
// An erase burst of N packets walks the single store write port over its
// N * PACKET_BYTES bytes, during which no input word is taken.
// The store needs no clearing pass after reset; cursors and control registers reset at once.
// A stalled output holds the pending stage and with it the input.
module packet_interleaver_with_burst_erasure_top #(
    parameter int PACKET_COUNT = pibe_pkg::PACKET_COUNT_DEF,
    parameter int PACKET_BYTES = pibe_pkg::PACKET_BYTES_DEF,
    parameter int MAX_STRIPE   = pibe_pkg::MAX_STRIPE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  pibe_pkg::pibe_in_t                in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output pibe_pkg::pibe_out_t               out_data,
    input  logic                              cfg_we,
    input  logic [pibe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pibe_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    import pibe_pkg::*;

    localparam int DEPTH = PACKET_COUNT * PACKET_BYTES;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = $clog2(PACKET_COUNT + 1);
    localparam int SW    = $clog2(MAX_STRIPE + 1);
    localparam int CW    = (BW > IN_USE_W) ? BW : IN_USE_W;

    typedef struct packed {
        logic                read_hit;
        logic [DONE_W-1:0]   done;
        logic                complete;
        logic [ERASED_W-1:0] erased;
        logic                ovf;
    } pend_t;

    logic [STRIPE_W-1:0] stripe_reg, stripe_next;
    logic [IN_USE_W-1:0] in_use_reg, in_use_next;
    logic [SW-1:0]       stripe_eff;

    pibe_state_t state_reg, state_next;
    logic        erase_busy;
    logic [AW-1:0] erase_addr_reg, erase_addr_next;
    logic [AW:0]   erase_cnt_reg, erase_cnt_next;

    logic        acc;
    pibe_op_t    op;
    logic        eob;

    logic [AW-1:0]     wr_addr, rd_addr;
    logic              wr_in_range, rd_in_range;
    logic              wr_group_end, rd_group_end;
    logic [BW-1:0]     wr_base_next, rd_base_next;
    logic [DONE_W-1:0] wr_done, rd_done;
    logic              wr_step, wr_clear, rd_step, rd_clear;
    logic              rd_complete;

    logic [IN_USE_W-1:0] limit;
    logic [IN_USE_W:0]   first_plus;
    logic [BURST_W-1:0]  erase_size;
    logic                erase_go;
    logic [AW-1:0]       erase_start;
    logic [AW:0]         erase_len;

    logic        ram_we, ram_re;
    logic [AW-1:0] ram_waddr;
    logic [7:0]  ram_wdata, ram_rdata;

    pend_t       pend_reg, pend_in;
    logic        pend_valid_reg, pend_valid_next;
    logic        pend_adv;
    logic        out_valid_reg, out_valid_next;
    pibe_out_t   out_data_reg;

    // Clamp the stripe into its working range
    always_comb
    begin
        if (stripe_reg == '0)
        begin
            stripe_eff = SW'(1);
        end
        else if (32'(stripe_reg) > MAX_STRIPE)
        begin
            stripe_eff = SW'(MAX_STRIPE);
        end
        else
        begin
            stripe_eff = SW'(stripe_reg);
        end
    end

    // Decode configuration writes
    always_comb
    begin
        stripe_next = stripe_reg;
        in_use_next = in_use_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STRIPE: stripe_next = STRIPE_W'(cfg_wdata);
                CFG_IN_USE: in_use_next = IN_USE_W'(cfg_wdata);
                default:    ;
            endcase
        end
    end

    assign acc = in_valid && in_ready;
    assign op  = in_data.opcode;
    assign eob = in_data.end_of_buffer;

    pibe_cursor #(
        .PACKET_COUNT (PACKET_COUNT),
        .PACKET_BYTES (PACKET_BYTES),
        .MAX_STRIPE   (MAX_STRIPE)
    ) u_wr_cursor (
        .clk              (clk),
        .rst_n            (rst_n),
        .stripe           (stripe_eff),
        .step             (wr_step),
        .clear            (wr_clear),
        .addr             (wr_addr),
        .in_range         (wr_in_range),
        .group_end        (wr_group_end),
        .base_next        (wr_base_next),
        .base_plus_stripe (wr_done)
    );

    pibe_cursor #(
        .PACKET_COUNT (PACKET_COUNT),
        .PACKET_BYTES (PACKET_BYTES),
        .MAX_STRIPE   (MAX_STRIPE)
    ) u_rd_cursor (
        .clk              (clk),
        .rst_n            (rst_n),
        .stripe           (stripe_eff),
        .step             (rd_step),
        .clear            (rd_clear),
        .addr             (rd_addr),
        .in_range         (rd_in_range),
        .group_end        (rd_group_end),
        .base_next        (rd_base_next),
        .base_plus_stripe (rd_done)
    );

    // Steer the cursors; a read pass ends once its group covers the packets in use
    always_comb
    begin
        rd_complete = rd_group_end
                      && ((CW'(rd_base_next) >= CW'(in_use_reg))
                          || (rd_base_next == BW'(PACKET_COUNT)));
        wr_step  = acc && (op == OP_WRITE) && !eob;
        wr_clear = acc && (((op == OP_WRITE) && eob) || (op == OP_REWIND));
        rd_step  = acc && (op == OP_READ) && !rd_complete;
        rd_clear = acc && (((op == OP_READ) && rd_complete) || (op == OP_REWIND));
    end

    // Clip the erase burst to the packets in use
    always_comb
    begin
        if (32'(in_use_reg) > PACKET_COUNT)
        begin
            limit = IN_USE_W'(PACKET_COUNT);
        end
        else
        begin
            limit = in_use_reg;
        end
        first_plus = (IN_USE_W + 1)'(in_data.burst_first_packet)
                     + (IN_USE_W + 1)'(in_data.burst_packets);
        if (IN_USE_W'(in_data.burst_first_packet) >= limit)
        begin
            erase_size = '0;
        end
        else if (first_plus > (IN_USE_W + 1)'(limit))
        begin
            erase_size = BURST_W'(limit - IN_USE_W'(in_data.burst_first_packet));
        end
        else
        begin
            erase_size = in_data.burst_packets;
        end
        erase_go    = acc && (op == OP_ERASE) && (erase_size != '0);
        erase_start = AW'(AW'(in_data.burst_first_packet) * AW'(PACKET_BYTES));
        erase_len   = (AW + 1)'((AW + 1)'(erase_size) * (AW + 1)'(PACKET_BYTES));
    end

    // Form the result status of the accepted word
    always_comb
    begin
        pend_in = '0;
        case (op)
            OP_WRITE:
            begin
                pend_in.ovf = !wr_in_range;
                if (eob)
                begin
                    pend_in.done     = wr_done;
                    pend_in.complete = 1'b1;
                end
            end
            OP_READ:
            begin
                pend_in.ovf      = !rd_in_range;
                pend_in.read_hit = rd_in_range;
                if (rd_complete)
                begin
                    pend_in.done     = DONE_W'(rd_base_next);
                    pend_in.complete = 1'b1;
                end
            end
            OP_ERASE:
            begin
                pend_in.erased = ERASED_W'(erase_len);
            end
            default: ;
        endcase
    end

    // Erase sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                if (erase_go)
                begin
                    state_next = ST_ERASE;
                end
            end
            ST_ERASE:
            begin
                if (erase_cnt_reg == (AW + 1)'(1))
                begin
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    // Erase sequencer: outputs
    always_comb
    begin
        erase_busy = 1'b0;
        unique case (state_reg)
            ST_RUN:   erase_busy = 1'b0;
            ST_ERASE: erase_busy = 1'b1;
            default:  erase_busy = 1'b0;
        endcase
        pend_adv = !out_valid_reg || out_ready;
        in_ready = !erase_busy && (!pend_valid_reg || pend_adv);
    end

    // Advance the erase walk
    always_comb
    begin
        erase_addr_next = erase_addr_reg;
        erase_cnt_next  = erase_cnt_reg;
        if (erase_go)
        begin
            erase_addr_next = erase_start;
            erase_cnt_next  = erase_len;
        end
        else if (erase_busy)
        begin
            erase_addr_next = erase_addr_reg + AW'(1);
            erase_cnt_next  = erase_cnt_reg - (AW + 1)'(1);
        end
    end

    // Drive the store ports
    always_comb
    begin
        ram_we    = erase_busy || (acc && (op == OP_WRITE) && wr_in_range);
        ram_waddr = erase_busy ? erase_addr_reg : wr_addr;
        ram_wdata = erase_busy ? ERASE_FILL : in_data.data_byte;
        ram_re    = acc && (op == OP_READ) && rd_in_range;
    end

    pibe_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Hand the pending word on to the output register
    always_comb
    begin
        if (acc)
        begin
            pend_valid_next = 1'b1;
        end
        else if (pend_adv)
        begin
            pend_valid_next = 1'b0;
        end
        else
        begin
            pend_valid_next = pend_valid_reg;
        end
        if (pend_valid_reg && pend_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stripe_reg     <= STRIPE_RESET;
            in_use_reg     <= IN_USE_RESET;
            state_reg      <= ST_RUN;
            erase_cnt_reg  <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            stripe_reg     <= stripe_next;
            in_use_reg     <= in_use_next;
            state_reg      <= state_next;
            erase_cnt_reg  <= erase_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Hold payload registers
    always_ff @(posedge clk)
    begin
        erase_addr_reg <= erase_addr_next;
        if (acc)
        begin
            pend_reg <= pend_in;
        end
        if (pend_valid_reg && pend_adv)
        begin
            out_data_reg.read_data     <= pend_reg.read_hit ? ram_rdata : 8'd0;
            out_data_reg.packets_done  <= pend_reg.done;
            out_data_reg.pass_complete <= pend_reg.complete;
            out_data_reg.erased_bytes  <= pend_reg.erased;
            out_data_reg.overflow      <= pend_reg.ovf;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // No word enters while the erase walk owns the store
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ERASE) |-> !in_ready)
        else $error("word taken during erase walk");

    // Writes and reads never share a cycle on the store
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("store write and read in one cycle");

    // The erase walk never runs on an empty count
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ERASE) |-> (erase_cnt_reg != '0))
        else $error("erase walk with zero count");

    // A pending result blocked by the output is kept
    assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid_reg && !pend_adv) |=> pend_valid_reg)
        else $error("pending result lost");

    // A finished group moves its base by the stripe unless held at the store end
    assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_group_end && (DONE_W'(wr_base_next) != wr_done)
          && (wr_base_next != BW'(PACKET_COUNT)))
        && !(rd_group_end && (DONE_W'(rd_base_next) != rd_done)
             && (rd_base_next != BW'(PACKET_COUNT))))
        else $error("group base moved by other than the stripe");

endmodule
